FILE: hw/rtl/amsg_pkg.sv
// amsg_pkg: shared types and constants for the AMSGrad update block.
// No dependencies.
`timescale 1ns / 1ps

package amsg_pkg;

    localparam int unsigned CfgIdxW = 2;

    typedef enum logic [CfgIdxW-1:0] {
        REG_STEP_SIZE    = 2'd0,
        REG_FIRST_DECAY  = 2'd1,
        REG_SECOND_DECAY = 2'd2,
        REG_STABILIZER   = 2'd3
    } t_cfg_reg;

    localparam int unsigned IdxW   = 12;
    localparam int unsigned ValW   = 32;
    localparam int unsigned AlphaW = 24;
    localparam int unsigned BetaW  = 16;
    localparam int unsigned EpsW   = 31;

endpackage

FILE: hw/rtl/amsgrad_optimizer_update_top.sv
// AMSGrad optimizer update: one gradient element per cycle when not stalled, one update
// out per element. The three moment stores share one wide memory with a registered read;
// uses amsg_pkg. A clearing pass after reset zeroes every entry and holds o_s_tready low.
// After it, items enter every cycle while the output is not stalled. Each item passes
// through the read and moment update, the square root pipeline, operand prep, the
// divider pipeline and the output register, in that order. A stalled output
// freezes the whole pipe. Back-to-back updates to the same index are forwarded
// from the pipeline stage that produced the newest moments.
`timescale 1ns / 1ps

module amsgrad_optimizer_update_top #(
    parameter int unsigned PARAM_COUNT = 4096,
    parameter int unsigned FRAC_BITS   = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input stream: tdata = {gradient[31:0], param_index[11:0]} (param_index low)
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,
    // output stream: tdata = {saturated, update[31:0], out_index[11:0]} (out_index low)
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata
);

    localparam int unsigned AW  = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
    localparam int unsigned SQN = 64;             // radicand bits
    localparam int unsigned SQS = SQN / 2;        // root iterations
    localparam int unsigned NUMW = 64;            // numerator bits
    localparam int unsigned DENW = 64;
    localparam int unsigned UP = (FRAC_BITS > 24) ? FRAC_BITS - 24 : 0;
    localparam int unsigned DN = (FRAC_BITS < 24) ? 24 - FRAC_BITS : 0;
    localparam int unsigned LAT = SQS + NUMW + 4;

    // ---------------- configuration ----------------
    logic [23:0] r_alpha;
    logic [15:0] r_b1, r_b2;
    logic [30:0] r_eps;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= '0; r_b1 <= '0; r_b2 <= '0; r_eps <= '0;
        end else if (i_cfg_valid) begin
            case (amsg_pkg::t_cfg_reg'(i_cfg_index))
                amsg_pkg::REG_STEP_SIZE:    r_alpha <= i_cfg_data[23:0];
                amsg_pkg::REG_FIRST_DECAY:  r_b1    <= i_cfg_data[15:0];
                amsg_pkg::REG_SECOND_DECAY: r_b2    <= i_cfg_data[15:0];
                amsg_pkg::REG_STABILIZER:   r_eps   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // ---------------- clearing pass ----------------
    logic          r_clr;
    logic [AW:0]   r_clr_cnt;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= 1'b1; r_clr_cnt <= '0;
        end else if (r_clr) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == (AW+1)'(PARAM_COUNT - 1)) r_clr <= 1'b0;
        end
    end

    // ---------------- pipeline control ----------------
    // Whole pipe advances when the output slot is free or being taken.
    logic w_adv;
    logic r_ov;
    assign w_adv      = !r_ov || i_m_tready;
    assign o_s_tready = w_adv && !r_clr;
    logic w_acc;
    assign w_acc = i_s_tvalid && o_s_tready;

    logic [11:0] w_in_idx;
    logic signed [31:0] w_in_g;
    assign w_in_idx = i_s_tdata[11:0];
    assign w_in_g   = i_s_tdata[43:12];

    // ---------------- memory ----------------
    // one entry = {vmax, v, m}
    logic [95:0] mem_st [PARAM_COUNT];
    logic [95:0] r_rd;

    // stage 1: read issued
    logic        r_s1_v, r_s1_in;
    logic [11:0] r_s1_idx;
    logic signed [31:0] r_s1_g;
    // stage 2: moments computed, written back
    logic        r_s2_v, r_s2_in;
    logic [11:0] r_s2_idx;
    logic signed [31:0] r_s2_m;
    logic [31:0] r_s2_vx;
    // gsq register kept with s1 (computed on input)
    logic [31:0] r_s1_gsq;

    // new moments of the item in stage 1
    logic signed [31:0] n_m;
    logic [31:0] n_v, n_vx;

    logic w_in_range;
    assign w_in_range = {20'd0, w_in_idx} < 32'(PARAM_COUNT);

    // gsq: g*g rounded, clamped
    logic [31:0] w_mag;
    logic [63:0] w_sq;
    logic [63:0] w_gsq64;
    always_comb begin
        w_mag   = w_in_g[31] ? 32'(-w_in_g) : w_in_g;
        w_sq    = {32'd0, w_mag} * {32'd0, w_mag};
        w_gsq64 = (w_sq + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            mem_st[r_clr_cnt[AW-1:0]] <= '0;
        end else if (w_adv && r_s1_v && r_s1_in) begin
            mem_st[AW'(r_s1_idx)] <= {n_vx, n_v, n_m};
        end
        if (w_adv) begin
            r_rd <= mem_st[AW'(w_in_idx)];
        end
    end

    // forwarding: the entry written at this edge by s1 is the newest value
    logic r_fwd;
    logic [31:0] r_f_m, r_f_v, r_f_vx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0; r_s2_v <= 1'b0; r_fwd <= 1'b0;
        end else if (w_adv) begin
            r_s1_v <= w_acc;
            r_s2_v <= r_s1_v;
            r_fwd  <= w_acc && r_s1_v && r_s1_in && (r_s1_idx == w_in_idx);
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_idx <= w_in_idx;
            r_s1_g   <= w_in_g;
            r_s1_in  <= w_in_range;
            r_s1_gsq <= (w_gsq64[63:32] != 0) ? 32'hFFFF_FFFF : w_gsq64[31:0];
            r_f_m  <= n_m;
            r_f_v  <= n_v;
            r_f_vx <= n_vx;
            r_s2_idx <= r_s1_idx;
            r_s2_in  <= r_s1_in;
            r_s2_m   <= n_m;
            r_s2_vx  <= n_vx;
        end
    end

    // stage 1 compute
    logic signed [31:0] w_om;
    logic [31:0] w_ov, w_ovx;
    logic signed [63:0] w_macc;
    logic [63:0] w_vacc;
    always_comb begin
        w_om  = r_fwd ? r_f_m  : r_rd[31:0];
        w_ov  = r_fwd ? r_f_v  : r_rd[63:32];
        w_ovx = r_fwd ? r_f_vx : r_rd[95:64];
        w_macc = $signed({48'd0, r_b1}) * 64'(w_om)
               + $signed(64'd65536 - {48'd0, r_b1}) * 64'(r_s1_g) + 64'sd32768;
        w_macc = w_macc >>> 16;
        if (w_macc > 64'sd2147483647)       n_m = 32'sh7FFF_FFFF;
        else if (w_macc < -64'sd2147483648) n_m = 32'sh8000_0000;
        else                                n_m = w_macc[31:0];
        w_vacc = {48'd0, r_b2} * {32'd0, w_ov}
               + (64'd65536 - {48'd0, r_b2}) * {32'd0, r_s1_gsq} + 64'd32768;
        w_vacc = w_vacc >> 16;
        n_v  = (w_vacc[63:32] != 0) ? 32'hFFFF_FFFF : w_vacc[31:0];
        n_vx = (n_v > w_ovx) ? n_v : w_ovx;
    end

    // ---------------- square root pipeline ----------------
    typedef struct packed {
        logic        inr;
        logic [11:0] idx;
        logic        neg;
        logic        zero;
        logic [31:0] mag;
    } t_tag;

    t_tag        r_sq_tag [SQS+1];
    logic [SQN-1:0] r_sq_x [SQS+1];
    logic [SQN-1:0] r_sq_r [SQS+1];
    logic [SQN-1:0] r_sq_b [SQS+1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq_tag[0] <= '{inr: r_s2_in, idx: r_s2_idx, neg: r_s2_m[31],
                             zero: (r_s2_m == 0),
                             mag: r_s2_m[31] ? 32'(-r_s2_m) : r_s2_m};
            r_sq_x[0] <= {32'd0, r_s2_vx} << FRAC_BITS;
            r_sq_r[0] <= '0;
            r_sq_b[0] <= 64'd1 << 62;
        end
    end

    for (genvar k = 0; k < SQS; k++) begin : g_sq
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sq_tag[k+1] <= r_sq_tag[k];
                r_sq_b[k+1]   <= r_sq_b[k] >> 2;
                if (r_sq_x[k] >= r_sq_r[k] + r_sq_b[k]) begin
                    r_sq_x[k+1] <= r_sq_x[k] - (r_sq_r[k] + r_sq_b[k]);
                    r_sq_r[k+1] <= (r_sq_r[k] >> 1) + r_sq_b[k];
                end else begin
                    r_sq_x[k+1] <= r_sq_x[k];
                    r_sq_r[k+1] <= r_sq_r[k] >> 1;
                end
            end
        end
    end

    // numerator / denominator prep
    t_tag        r_p_tag;
    logic [NUMW-1:0] r_p_num;
    logic [DENW-1:0] r_p_den;
    logic [32:0] w_den33;
    assign w_den33 = 33'(r_sq_r[SQS]) + {2'd0, r_eps};
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_tag <= r_sq_tag[SQS];
            r_p_num <= ({40'd0, r_alpha} * {32'd0, r_sq_tag[SQS].mag}) << UP;
            r_p_den <= {31'd0, w_den33} << DN;
        end
    end

    // ---------------- restoring divider pipeline ----------------
    // numerator gets den/2 added; quotient developed one bit per stage.
    t_tag            r_dv_tag [NUMW+1];
    logic [NUMW-1:0] r_dv_n   [NUMW+1];
    logic [DENW:0]   r_dv_rem [NUMW+1];
    logic [DENW-1:0] r_dv_d   [NUMW+1];
    logic [NUMW-1:0] r_dv_q   [NUMW+1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv_tag[0] <= r_p_tag;
            r_dv_n[0]   <= r_p_num + (r_p_den >> 1);
            r_dv_rem[0] <= '0;
            r_dv_d[0]   <= r_p_den;
            r_dv_q[0]   <= '0;
        end
    end

    for (genvar k = 0; k < NUMW; k++) begin : g_dv
        logic [DENW:0] w_t;
        assign w_t = {r_dv_rem[k][DENW-1:0], r_dv_n[k][NUMW-1]};
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_tag[k+1] <= r_dv_tag[k];
                r_dv_n[k+1]   <= r_dv_n[k] << 1;
                r_dv_d[k+1]   <= r_dv_d[k];
                if (w_t >= {1'b0, r_dv_d[k]}) begin
                    r_dv_rem[k+1] <= w_t - {1'b0, r_dv_d[k]};
                    r_dv_q[k+1]   <= {r_dv_q[k][NUMW-2:0], 1'b1};
                end else begin
                    r_dv_rem[k+1] <= w_t;
                    r_dv_q[k+1]   <= {r_dv_q[k][NUMW-2:0], 1'b0};
                end
            end
        end
    end

    // ---------------- result and output register ----------------
    t_tag        w_ft;
    logic [NUMW-1:0] w_q;
    logic        w_dz;
    logic        r_dz_pipe [NUMW+1];
    logic signed [31:0] w_upd;
    logic        w_flag;

    always_ff @(posedge i_clk) begin
        if (w_adv) r_dz_pipe[0] <= (r_p_den == 0);
    end
    for (genvar k = 0; k < NUMW; k++) begin : g_dz
        always_ff @(posedge i_clk) begin
            if (w_adv) r_dz_pipe[k+1] <= r_dz_pipe[k];
        end
    end

    always_comb begin
        w_ft = r_dv_tag[NUMW];
        w_q  = r_dv_q[NUMW];
        w_dz = r_dz_pipe[NUMW];
        w_upd = '0; w_flag = 1'b0;
        if (w_ft.inr) begin
            if (w_dz) begin
                w_flag = 1'b1;
            end else if (w_ft.zero) begin
                w_upd = '0;
            end else if (!w_ft.neg) begin
                if (w_q > 64'd2147483648) begin
                    w_upd = 32'sh8000_0000; w_flag = 1'b1;
                end else w_upd = 32'(-w_q[31:0]);
            end else begin
                if (w_q > 64'd2147483647) begin
                    w_upd = 32'sh7FFF_FFFF; w_flag = 1'b1;
                end else w_upd = w_q[31:0];
            end
        end
    end

    // valid bits travel in their own reset shift register, in step with the payload
    logic [LAT-2:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_adv) r_vld <= {r_vld[LAT-3:0], r_s2_v};
    end

    logic [47:0] r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_adv) r_ov <= r_vld[LAT-2];
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) r_out <= {3'd0, w_flag, w_upd, w_ft.idx};
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_out;

`ifndef NO_ASSERTIONS
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_m_tready |=> r_ov) else $error("lost result");
    a_no_acc_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !o_s_tready) else $error("accept during clear");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_m_tready |=> $stable(o_m_tdata)) else $error("output changed");
`endif

endmodule

FILE: bench/amsgrad_optimizer_update_top_tb.sv
// Self-checking bench for amsgrad_optimizer_update_top: directed and random gradient
// streams with random idling on both sides, checked against a built-in moment predictor.
// Depends on amsg_pkg and the top-level RTL.
`timescale 1ns / 1ps

module amsgrad_optimizer_update_top_tb;

    localparam int unsigned NPARAM   = 4096;
    localparam int unsigned FRAC     = 24;
    localparam int          DRAIN    = 160;  // idle wait after the expected-update queue empties

    typedef struct {
        logic [amsg_pkg::IdxW-1:0] idx;
        logic [amsg_pkg::ValW-1:0] upd;
        logic                      sat;
    } t_update;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;   // [11:0] param_index, [43:12] gradient
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;   // [11:0] out_index, [43:12] update, [44] saturated

    amsgrad_optimizer_update_top uut (.*);

    // predictor state
    logic [amsg_pkg::AlphaW-1:0] alpha;
    logic [amsg_pkg::BetaW-1:0]  beta1, beta2;
    logic [amsg_pkg::EpsW-1:0]   eps;
    logic signed [31:0]    m_store   [NPARAM];
    logic [31:0]           v_store   [NPARAM];
    logic [31:0]           vmax_store[NPARAM];

    t_update pending_updates[$];
    int      n_errors;
    bit      rx_no_stall;   // receiver accepts every cycle while set
    bit      tx_no_gap;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("amsgrad_optimizer_update_top regression: fail");
        $finish;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // advances the moment stores and returns the expected update
    function automatic t_update predict_update(logic [amsg_pkg::IdxW-1:0] idx,
                                               logic signed [31:0] grad);
        t_update         res;
        longint          g, b1, m_new;
        longint unsigned mag, gsq, v_new, vmax, den, q;
        g  = longint'(grad);
        b1 = longint'(beta1);
        res.idx = idx;
        res.upd = '0;
        res.sat = 1'b0;
        m_new = (b1 * longint'(m_store[idx]) + (65536 - b1) * g + 32768) >>> 16;
        if (m_new > 64'sd2147483647) m_new = 64'sd2147483647;
        if (m_new < -64'sd2147483648) m_new = -64'sd2147483648;
        m_store[idx] = m_new[31:0];

        mag = (g < 0) ? longint'(-g) : longint'(g);
        gsq = (mag * mag + (64'h1 << (FRAC - 1))) >> FRAC;
        if (gsq > 64'hFFFF_FFFF) gsq = 64'hFFFF_FFFF;
        v_new = (64'(beta2) * 64'(v_store[idx]) + (64'd65536 - 64'(beta2)) * gsq
                 + 64'd32768) >> 16;
        if (v_new > 64'hFFFF_FFFF) v_new = 64'hFFFF_FFFF;
        v_store[idx] = v_new[31:0];
        vmax = 64'(vmax_store[idx]);
        if (v_new > vmax) vmax = v_new;
        vmax_store[idx] = vmax[31:0];

        den = int_sqrt(vmax << FRAC) + 64'(eps);
        if (den == 0) begin
            res.sat = 1'b1;
        end else begin
            mag = (m_new < 0) ? longint'(-m_new) : longint'(m_new);
            q = (64'(alpha) * mag + (den >> 1)) / den;
            if (m_new > 0) begin
                if (q > 64'd2147483648) begin
                    q = 64'd2147483648;
                    res.sat = 1'b1;
                end
                res.upd = 32'(-longint'(q));
            end else if (m_new < 0) begin
                if (q > 64'd2147483647) begin
                    q = 64'd2147483647;
                    res.sat = 1'b1;
                end
                res.upd = q[31:0];
            end
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // receiver stalls
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_no_stall) begin
                i_m_tready = 1'b1;
            end else if (i_m_tready) begin
                i_m_tready = ($urandom_range(0, 99) < 75);
            end else begin
                i_m_tready = 1'b0;
                repeat (pick_gap()) @(negedge i_clk);
                i_m_tready = 1'b1;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_update exp_u;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_updates.size() == 0) begin
                $display("%0t: unexpected update transfer %h", $time, o_m_tdata);
                n_errors++;
            end else begin
                exp_u = pending_updates.pop_front();
                if (o_m_tdata[11:0] !== exp_u.idx) begin
                    $display("%0t: out_index expected %0d actual %0d",
                             $time, exp_u.idx, o_m_tdata[11:0]);
                    n_errors++;
                end
                if (o_m_tdata[43:12] !== exp_u.upd) begin
                    $display("%0t: update[%0d] expected %h actual %h",
                             $time, exp_u.idx, exp_u.upd, o_m_tdata[43:12]);
                    n_errors++;
                end
                if (o_m_tdata[44] !== exp_u.sat) begin
                    $display("%0t: saturated[%0d] expected %b actual %b",
                             $time, exp_u.idx, exp_u.sat, o_m_tdata[44]);
                    n_errors++;
                end
            end
        end
    end

    // called right after a falling edge
    task automatic send_gradient(logic [amsg_pkg::IdxW-1:0] idx, logic signed [31:0] grad);
        int gap;
        gap = tx_no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {4'b0, grad, idx};
        do @(posedge i_clk); while (!o_s_tready);
        pending_updates.push_back(predict_update(idx, grad));
        @(negedge i_clk);
    endtask

    task automatic write_reg(amsg_pkg::t_cfg_reg reg_sel, logic [31:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = reg_sel;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (reg_sel)
            amsg_pkg::REG_STEP_SIZE:    alpha = value[amsg_pkg::AlphaW-1:0];
            amsg_pkg::REG_FIRST_DECAY:  beta1 = value[amsg_pkg::BetaW-1:0];
            amsg_pkg::REG_SECOND_DECAY: beta2 = value[amsg_pkg::BetaW-1:0];
            amsg_pkg::REG_STABILIZER:   eps   = value[amsg_pkg::EpsW-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        i_s_tvalid = 1'b0;
        while (pending_updates.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    task automatic load_config(logic [31:0] a, logic [31:0] b1, logic [31:0] b2,
                               logic [31:0] e);
        wait_drained();
        write_reg(amsg_pkg::REG_STEP_SIZE, a);
        write_reg(amsg_pkg::REG_FIRST_DECAY, b1);
        write_reg(amsg_pkg::REG_SECOND_DECAY, b2);
        write_reg(amsg_pkg::REG_STABILIZER, e);
    endtask

    // registers at reset values: zero step size; zero denominator on entry 7
    task automatic test_reset_config();
        send_gradient(12'd7, 32'sd0);
        send_gradient(12'd8, 32'sd16777216);
        send_gradient(12'd8, -32'sd16777216);
    endtask

    task automatic test_field_extremes();
        load_config(32'h0080_0000, 32'd58982, 32'd65209, 32'd168);
        send_gradient(12'd0, 32'sh7FFF_FFFF);
        send_gradient(12'd4095, 32'sh8000_0000);
        send_gradient(12'd0, 32'sh8000_0000);
        send_gradient(12'd4095, 32'sd1);
        send_gradient(12'd0, -32'sd1);
        send_gradient(12'd100, 32'sd0);
        send_gradient(12'd100, 32'sh00FF_FFFF);
        send_gradient(12'd2730, 32'sh5555_5555);
        send_gradient(12'd1365, 32'shAAAA_AAAA);
    endtask

    // large step, tiny epsilon, slow v: the quotient clips both ways; then huge epsilon
    task automatic test_clipping();
        load_config(32'hFFFF_FFFF, 32'd0, 32'd65535, 32'd0);
        send_gradient(12'd200, 32'sh7FFF_FFFF);
        send_gradient(12'd201, 32'sh8000_0000);
        send_gradient(12'd202, 32'sd0);          // zero denominator
        send_gradient(12'd200, 32'sh8000_0000);
        send_gradient(12'd203, 32'sd1);
        load_config(32'h00FF_FFFF, 32'd65535, 32'd0, 32'h7FFF_FFFF);
        send_gradient(12'd200, 32'sh7FFF_FFFF);
        send_gradient(12'd204, 32'sh8000_0000);
        send_gradient(12'd204, 32'sh8000_0000);
    endtask

    task automatic test_random_phase(int count, int idx_pool);
        logic [amsg_pkg::IdxW-1:0] idx;
        logic signed [31:0]        grad;
        int                        r;
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0) begin
                tx_no_gap   = ($urandom_range(0, 3) == 0);
                rx_no_stall = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 9);
            if (r < 6) idx = amsg_pkg::IdxW'($urandom_range(0, idx_pool - 1));
            else if (r < 8) idx = amsg_pkg::IdxW'($urandom_range(0, NPARAM - 1));
            else idx = i_s_tdata[11:0];    // same index back to back
            r = $urandom_range(0, 9);
            if (r < 4) grad = $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
            else if (r < 8) grad = $urandom;
            else if (r < 9) grad = $signed($urandom_range(0, 4096)) - 32'sd2048;
            else grad = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            send_gradient(idx, grad);
        end
        tx_no_gap   = 1'b0;
        rx_no_stall = 1'b0;
    endtask

    task automatic test_random_configs();
        load_config(32'h0010_0000, 32'd58982, 32'd65209, 32'd168);
        test_random_phase(320, 16);
        load_config($urandom, $urandom, $urandom, $urandom);
        test_random_phase(300, 64);
        load_config(32'hFFFF_FFFF, 32'd65535, 32'd65535, 32'd0);
        test_random_phase(300, 8);
        load_config(32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF);
        test_random_phase(150, 32);
        load_config(32'd1, 32'd0, 32'd65535, 32'd1);
        test_random_phase(150, 4096);
        load_config($urandom, $urandom, $urandom, $urandom_range(0, 255));
        test_random_phase(300, 32);
    endtask

    initial begin
        n_errors    = 0;
        rx_no_stall = 1'b0;
        tx_no_gap   = 1'b0;
        alpha = '0;
        beta1 = '0;
        beta2 = '0;
        eps   = '0;
        for (int k = 0; k < NPARAM; k++) begin
            m_store[k]    = '0;
            v_store[k]    = '0;
            vmax_store[k] = '0;
        end
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = amsg_pkg::REG_STEP_SIZE;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_config();
        test_field_extremes();
        test_clipping();
        test_random_configs();

        wait_drained();
        if (n_errors == 0) begin
            $display("amsgrad_optimizer_update_top regression: pass");
        end else begin
            $display("amsgrad_optimizer_update_top regression: fail");
        end
        $finish;
    end

endmodule

FILE: amsgrad_optimizer_update_top.f
hw/rtl/amsg_pkg.sv
hw/rtl/amsgrad_optimizer_update_top.sv
bench/amsgrad_optimizer_update_top_tb.sv
